// ===== rtl/core/sidec_pkg.sv =====
// shared constants and types for the signed integer to decimal text converter
// no dependencies
`default_nettype none
package sidec_pkg;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned MAG_W    = 32;
	localparam int unsigned NDIG     = 10;
	localparam int unsigned BCD_W    = 4 * NDIG;
	localparam int unsigned CODE_W   = 6;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned NSTAGE   = 4;
	localparam int unsigned BITS_PER = MAG_W / NSTAGE;
	localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;

	typedef struct packed {
		logic              neg;
		logic [MAG_W-1:0]  mag;
		logic [BCD_W-1:0]  bcd;
	} conv_t;

	// one double-dabble step: add 3 to every digit of 5 or more, then shift in a bit
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
		logic [BCD_W-1:0] t;
		t = b;
		for (int d = 0; d < NDIG; d++) begin
			if (t[4*d +: 4] >= 4'd5) begin
				t[4*d +: 4] = t[4*d +: 4] + 4'd3;
			end
		end
		return {t[BCD_W-2:0], bit_in};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sidec_dabble_stage.sv =====
// one pipeline stage of the binary to bcd conversion, eight bits per stage
// depends on sidec_pkg
`default_nettype none
module sidec_dabble_stage import sidec_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  conv_t      in_data,
	output logic       out_valid,
	output conv_t      out_data
);
	conv_t nxt;

	always_comb begin
		nxt = in_data;
		for (int i = 0; i < BITS_PER; i++) begin
			nxt.bcd = dabble(nxt.bcd, nxt.mag[MAG_W-1]);
			nxt.mag = {nxt.mag[MAG_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/sidec_serializer.sv =====
// sends the sign and digits of one converted number as a run of characters
// depends on sidec_pkg
`default_nettype none
module sidec_serializer import sidec_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  conv_t                   in_data,
	output logic                    in_stall,
	output logic                    valid,
	input  wire logic               stall,
	output logic [CODE_W-1:0]       char_code,
	output logic                    last_char
);
	logic              busy_q;
	logic              sign_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  first;
	logic              take;
	logic              fire;

	// most significant non-zero digit, digit 0 at least
	always_comb begin
		first = '0;
		for (int d = 1; d < NDIG; d++) begin
			if (in_data.bcd[4*d +: 4] != 4'd0) begin
				first = CNT_W'(d);
			end
		end
	end

	assign in_stall = busy_q;
	assign take     = in_valid && !busy_q;
	assign fire     = valid && !stall;
	assign valid    = busy_q;
	assign char_code = sign_q ? CHAR_MINUS : (CHAR_ZERO + CODE_W'(bcd_q[4*idx_q +: 4]));
	assign last_char = !sign_q && (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (fire && last_char) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sign_q <= in_data.neg;
			bcd_q  <= in_data.bcd;
			idx_q  <= first;
		end else if (fire) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !(fire && last_char) |=> busy_q)
		else $error("serializer dropped a run");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !take)
		else $error("took a transaction while busy");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_char |=> !busy_q || $past(take))
		else $error("run did not end");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// signed 32-bit integer to decimal ascii text, top level
// an accepted input transaction passes the magnitude register, four conversion stages and the
// serializer register before its first character, then one character per cycle while stall is low
// the serializer takes a new number only after the last character of the one it holds (1 to 11 characters)
// reset: asynchronous active low, clears all valid bits; no other state kept
// depends on sidec_pkg, sidec_dabble_stage, sidec_serializer
`default_nettype none
module signed_int_to_decimal_ascii import sidec_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                      valid,
	input  wire logic                 stall,
	output logic [CODE_W-1:0]         char_code,
	output logic                      last_char
);
	// stage valids and data, index 0 is the magnitude register
	logic  v_s [NSTAGE+1];
	conv_t d_s [NSTAGE+1];
	logic  ser_stall;
	logic  en;

	// pipeline advances unless its last stage is full and the serializer is busy
	assign en       = !(v_s[NSTAGE] && ser_stall);
	assign in_stall = !en;

	// stage one: sign and 32-bit magnitude (0x80000000 fits unsigned)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0].neg <= value[VAL_W-1];
			d_s[0].mag <= value[VAL_W-1] ? (~value + 1'b1) : value;
			d_s[0].bcd <= '0;
		end
	end

	// double-dabble split over stages, eight magnitude bits each
	for (genvar g = 0; g < NSTAGE; g++) begin : g_dab
		sidec_dabble_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_s[g]),
			.in_data  (d_s[g]),
			.out_valid(v_s[g+1]),
			.out_data (d_s[g+1])
		);
	end

	// character serializer with its own output register
	sidec_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s[NSTAGE]),
		.in_data  (d_s[NSTAGE]),
		.in_stall (ser_stall),
		.valid    (valid),
		.stall    (stall),
		.char_code(char_code),
		.last_char(last_char)
	);

`ifndef ASSERT_OFF
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NSTAGE] && ser_stall |=> v_s[NSTAGE] && $stable(d_s[NSTAGE]))
		else $error("last pipeline stage lost a transaction");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s[NSTAGE])
		else $error("input stalled with empty pipeline");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (char_code == CHAR_MINUS) || (char_code >= CHAR_ZERO && char_code <= 6'd57))
		else $error("bad character code");
`endif
endmodule
`default_nettype wire
